// ===== rtl/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and codes for the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int FIELD_BITS   = 32;
    localparam int ADDRESS_BITS = 32;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOTUSED = 2'd2;

    typedef struct packed {
        logic                  action;
        logic [FIELD_BITS-1:0] request_size;
        logic [FIELD_BITS-1:0] region_address;
    } req_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] granted_address;
        logic [1:0]            status;
    } rsp_t;

endpackage

// ===== rtl/ffra_table.sv =====
// ----------------------------------------------------------------------------
// ffra_table
// Region table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffra_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 32,
    parameter int IW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  logic [2*AW:0] wdata,
    input  logic [IW-1:0] raddr,
    output logic [2*AW:0] rdata
);
    // entry layout: {start, length, free}
    logic [2*AW:0] mem [DEPTH];

    // synchronous write and read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/first_fit_region_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit allocator over an address-ordered region table with coalescing.
// ----------------------------------------------------------------------------
// Usage: a request transaction (allocate or free) enters on req_* when
// req_valid is high and req_stall low. One response transaction leaves on
// rsp_* per request. Requests are handled one at a time; the table lives in
// a memory with one registered read port, so entries are read before use.
// Steps: allocate scans entries up to the first free fit, then a split
// shifts the tail up by one entry; free scans to the match, then each merge
// shifts the tail down. A zero-size allocate answers without a table scan.
// Reset clears the region count and the bump pointer; table contents are
// never read beyond the count, so no clearing pass is needed. A stalled
// response holds in the output register and blocks the next request until
// it is taken.
// ----------------------------------------------------------------------------
module first_fit_region_allocator #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ffra_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ffra_pkg::rsp_t rsp
);
    import ffra_pkg::*;

    localparam int AW = ADDRESS_BITS;
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [AW-1:0] AMAX = {AW{1'b1}};
    localparam logic [CW-1:0] CDEPTH = CW'(TABLE_DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;  // scan: issue read
    localparam logic [3:0] S_SCHK  = 4'd2;  // scan: check entry
    localparam logic [3:0] S_UPRD  = 4'd3;  // shift up: read
    localparam logic [3:0] S_UPWR  = 4'd4;  // shift up: write
    localparam logic [3:0] S_DNRD  = 4'd5;  // shift down: read
    localparam logic [3:0] S_DNWR  = 4'd6;  // shift down: write
    localparam logic [3:0] S_NBRD  = 4'd7;  // read neighbour
    localparam logic [3:0] S_NBCHK = 4'd8;  // check neighbour
    localparam logic [3:0] S_FIN   = 4'd9;  // final write
    localparam logic [3:0] S_RSP   = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] bump_reg, bump_next;
    logic [CW-1:0] idx_reg, idx_next;     // scan / shift pointer
    logic [CW-1:0] pos_reg, pos_next;     // hit position
    logic          act_reg, act_next;
    logic [AW-1:0] size_reg, size_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] hs_reg, hs_next;       // hit start
    logic [AW-1:0] hl_reg, hl_next;       // hit length (accumulated)
    logic          merged_reg, merged_next; // left merge done
    rsp_t          rsp_reg, rsp_next;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [2*AW:0] wdata, rdata;
    logic [AW-1:0] r_start, r_len;
    logic          r_free;
    logic [CW-1:0] idx_dec, idx_inc;

    ffra_table #(.DEPTH(TABLE_DEPTH), .AW(AW), .IW(IW)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign r_start = rdata[2*AW:AW+1];
    assign r_len   = rdata[AW:1];
    assign r_free  = rdata[0];

    // neighbour slots of the shift pointer
    assign idx_dec = idx_reg - 1'b1;
    assign idx_inc = idx_reg + 1'b1;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_RSP);
    assign rsp       = rsp_reg;

    // control sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        bump_next   = bump_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        act_next    = act_reg;
        size_next   = size_reg;
        addr_next   = addr_reg;
        hs_next     = hs_reg;
        hl_next     = hl_reg;
        merged_next = merged_reg;
        rsp_next    = rsp_reg;
        we          = 1'b0;
        waddr       = idx_reg[IW-1:0];
        wdata       = '0;
        raddr       = idx_reg[IW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next    = req.action;
                    size_next   = AW'(req.request_size);
                    addr_next   = AW'(req.region_address);
                    idx_next    = '0;
                    merged_next = 1'b0;
                    rsp_next    = '{granted_address: '0, status: ST_OK};
                    state_next  = S_SRD;
                    if (req.action == ACT_ALLOC && req.request_size == '0)
                    begin
                        rsp_next.granted_address = FIELD_BITS'(bump_reg);
                        state_next = S_RSP;
                    end
                end
            end
            S_SRD:
            begin
                if (idx_reg >= count_reg)
                begin
                    if (act_reg == ACT_FREE)
                    begin
                        rsp_next.status = ST_NOTUSED;
                        state_next = S_RSP;
                    end
                    else if (count_reg >= CDEPTH || size_reg > AMAX - bump_reg)
                    begin
                        rsp_next.status = ST_FULL;
                        state_next = S_RSP;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[IW-1:0];
                        wdata      = {bump_reg, size_reg, 1'b0};
                        count_next = count_reg + 1'b1;
                        bump_next  = bump_reg + size_reg;
                        rsp_next.granted_address = FIELD_BITS'(bump_reg);
                        state_next = S_RSP;
                    end
                end
                else
                begin
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                hs_next  = r_start;
                hl_next  = r_len;
                pos_next = idx_reg;
                if (act_reg == ACT_ALLOC)
                begin
                    if (r_free && r_len >= size_reg)
                    begin
                        rsp_next.granted_address = FIELD_BITS'(r_start);
                        if (r_len == size_reg)
                        begin
                            we    = 1'b1;
                            wdata = {r_start, r_len, 1'b0};
                            state_next = S_RSP;
                        end
                        else if (count_reg >= CDEPTH)
                        begin
                            rsp_next = '{granted_address: '0, status: ST_FULL};
                            state_next = S_RSP;
                        end
                        else
                        begin
                            // shift tail up from the last entry
                            we    = 1'b1;
                            wdata = {r_start, size_reg, 1'b0};
                            idx_next   = count_reg;
                            state_next = S_UPRD;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SRD;
                    end
                end
                else
                begin
                    if (!r_free && r_start == addr_reg)
                    begin
                        if (idx_reg != '0)
                        begin
                            idx_next   = idx_reg - 1'b1;
                            state_next = S_NBRD;
                        end
                        else
                        begin
                            merged_next = 1'b1;
                            idx_next    = idx_reg + 1'b1;
                            state_next  = S_NBRD;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SRD;
                    end
                end
            end
            S_UPRD:
            begin
                // idx is the destination slot; read idx-1
                raddr = idx_dec[IW-1:0];
                if (idx_reg == pos_reg + 1'b1)
                begin
                    we    = 1'b1;
                    wdata = {hs_reg + size_reg, hl_reg - size_reg, 1'b1};
                    count_next = count_reg + 1'b1;
                    state_next = S_RSP;
                end
                else
                begin
                    state_next = S_UPWR;
                end
            end
            S_UPWR:
            begin
                we         = 1'b1;
                wdata      = rdata;
                idx_next   = idx_reg - 1'b1;
                state_next = S_UPRD;
            end
            S_NBRD:
            begin
                // merged_reg clear: idx = left neighbour; set: idx = right
                if (merged_reg && idx_reg >= count_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_NBCHK;
                end
            end
            S_NBCHK:
            begin
                if (!merged_reg)
                begin
                    merged_next = 1'b1;
                    if (r_free)
                    begin
                        hs_next  = r_start;
                        hl_next  = hl_reg + r_len;
                        pos_next = idx_reg;
                        // drop entry pos+1 (old hit): shift down from pos+1
                        idx_next   = pos_reg;
                        count_next = count_reg - 1'b1;
                        state_next = S_DNRD;
                    end
                    else
                    begin
                        idx_next   = pos_reg + 1'b1;
                        state_next = S_NBRD;
                    end
                end
                else
                begin
                    if (r_free)
                    begin
                        hl_next    = hl_reg + r_len;
                        idx_next   = idx_reg;
                        count_next = count_reg - 1'b1;
                        state_next = S_DNRD;
                        act_next   = ACT_ALLOC; // marks final shift pass
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_DNRD:
            begin
                // idx is the destination slot; read idx+1
                raddr = idx_inc[IW-1:0];
                if (idx_reg >= count_reg)
                begin
                    if (act_reg == ACT_ALLOC)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        idx_next   = pos_reg + 1'b1;
                        state_next = S_NBRD;
                    end
                end
                else
                begin
                    state_next = S_DNWR;
                end
            end
            S_DNWR:
            begin
                we         = 1'b1;
                wdata      = rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = S_DNRD;
            end
            S_FIN:
            begin
                we         = 1'b1;
                waddr      = pos_reg[IW-1:0];
                wdata      = {hs_reg, hl_reg, 1'b1};
                state_next = S_RSP;
            end
            S_RSP:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            bump_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bump_reg  <= bump_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        act_reg    <= act_next;
        size_reg   <= size_next;
        addr_reg   <= addr_next;
        hs_reg     <= hs_next;
        hl_reg     <= hl_next;
        merged_reg <= merged_next;
        rsp_reg    <= rsp_next;
    end

    // region count never exceeds the table
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CDEPTH) else $error("region count overflow");
    // a held response keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reg))
        else $error("response changed under stall");
    // bump pointer only moves up
    a_bump: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg >= $past(bump_reg)) else $error("bump pointer moved down");
    // no table write while idle
    a_idle_we: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !we) else $error("write while idle");
endmodule
